// ----- design/oahi_pkg.sv -----
// Shared types and constants for the open-address hash insert block.
`default_nettype none
package oahi_pkg;
  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned KeyW = 44;
  localparam int unsigned RecW = 16;
  localparam int unsigned SizeW = 11;
  // Hash value reaches 3330 and fold step 165 when nibbles run up to 15.
  localparam int unsigned HvW = 12;
  localparam int unsigned StepW = 8;

  localparam logic [1:0] CfgHashMethod = 2'd0;
  localparam logic [1:0] CfgTableSize  = 2'd1;

  typedef struct packed {
    logic [KeyW-1:0] key_bcd;
    logic [RecW-1:0] record_ref;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  slot;
    logic        outcome;
    logic [10:0] probe_collisions;
    logic [31:0] total_inserts;
    logic [31:0] total_collisions;
    logic [31:0] total_replacements;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [RecW-1:0]  rec;
    logic [HvW-1:0]   hv;
    logic [StepW-1:0] step;
  } job_t;

  function automatic logic [3:0] digit_at(logic [KeyW-1:0] key, int unsigned n);
    digit_at = key[4*(11-n) +: 4];
  endfunction
endpackage
`default_nettype wire

// ----- design/oahi_front.sv -----
// Front part: hashes the key and queues the classified item.
`default_nettype none
module oahi_front import oahi_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     hash_method_i,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          job_valid_o,
  input  wire logic     job_ready_i,
  output job_t          job_o
);
  // Two-entry queue.
  job_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  job_t       job_d;
  logic [3:0] d [1:11];
  logic       push, pop;

  always_comb begin
    for (int n = 1; n <= 11; n++) d[n] = digit_at(in_data_i.key_bcd, n);
    job_d.key = in_data_i.key_bcd;
    job_d.rec = in_data_i.record_ref;
    if (!hash_method_i) begin
      job_d.hv = HvW'(d[1]) * HvW'(100) + HvW'(d[3]) * HvW'(10) + HvW'(d[4]);
      job_d.step = StepW'(d[5]);
    end else begin
      job_d.hv = HvW'(d[6]) * HvW'(100) + HvW'(d[7]) * HvW'(10) + HvW'(d[11])
               + HvW'(d[8]) * HvW'(100) + HvW'(d[9]) * HvW'(10) + HvW'(d[10]);
      job_d.step = StepW'(d[6]) * StepW'(10) + StepW'(d[11]);
    end
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign push        = in_valid_i && in_ready_o;
  assign job_valid_o = cnt_q != 2'd0;
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue lost an entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !push) |=> !job_valid_o)
    else $error("empty queue shows valid");
endmodule
`default_nettype wire

// ----- design/oahi_back.sv -----
// Back part: modulo unit, probe walk over the table memory, counters.
`default_nettype none
module oahi_back import oahi_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [10:0] table_size_i,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  wire job_t        job_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o
);
  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned SW = AW + 1;
  localparam int unsigned PW = (SW > 11) ? SW : 11;
  localparam int unsigned RW = (SW > HvW) ? SW : HvW;

  typedef enum logic [2:0] {S_IDLE, S_MOD, S_STEP, S_CLR, S_RD, S_CHK, S_OUT} state_e;
  state_e state_q;

  logic            occ_mem [TableDepth];
  logic [KeyW-1:0] key_mem [TableDepth];
  logic [RecW-1:0] rec_mem [TableDepth];

  logic [SW-1:0] size_q, pos_q, home_q;
  logic [RW-1:0] mrem_q, step_q;
  logic [AW-1:0] clr_q;
  logic [PW-1:0] steps_q, probes_q;
  logic          occ_rd_q, done_clr_q;
  job_t          job_q;
  logic [31:0]   ins_q, col_q, rep_q;
  out_item_t     out_q;
  logic [SW-1:0] size_eff, nxt;
  logic [SW:0]   sum;

  always_comb begin
    if (table_size_i == 11'd0) size_eff = SW'(1);
    else if (PW'(table_size_i) > PW'(TableDepth)) size_eff = SW'(TableDepth);
    else size_eff = SW'(table_size_i);
    sum = {1'b0, pos_q} + {1'b0, step_q[SW-1:0]};
    nxt = (sum >= {1'b0, size_q}) ? SW'(sum - {1'b0, size_q}) : SW'(sum);
  end

  assign job_ready_o = (state_q == S_IDLE) && done_clr_q;
  assign out_valid_o = state_q == S_OUT;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) occ_mem[clr_q] <= 1'b0;
    else if (state_q == S_CHK && (!occ_rd_q || steps_q == PW'(size_q))) begin
      occ_mem[pos_q[AW-1:0]] <= 1'b1;
    end
    if (state_q == S_CHK && (!occ_rd_q || steps_q == PW'(size_q))) begin
      key_mem[(!occ_rd_q) ? pos_q[AW-1:0] : home_q[AW-1:0]] <= job_q.key;
      rec_mem[(!occ_rd_q) ? pos_q[AW-1:0] : home_q[AW-1:0]] <= job_q.rec;
    end
    occ_rd_q <= occ_mem[pos_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; done_clr_q <= 1'b0;
      ins_q <= '0; col_q <= '0; rep_q <= '0;
      job_q <= '0; size_q <= '0; mrem_q <= '0; step_q <= '0;
      pos_q <= '0; home_q <= '0; steps_q <= '0; probes_q <= '0;
      out_q <= '0;
    end else begin
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(TableDepth - 1)) begin
            done_clr_q <= 1'b1; state_q <= S_IDLE;
          end
        end
        S_IDLE: if (job_valid_i) begin
          job_q <= job_i; size_q <= size_eff;
          mrem_q <= RW'(job_i.hv); step_q <= RW'(job_i.step);
          state_q <= S_MOD;
        end
        S_MOD: begin  // repeated subtraction, hv < 4096
          if (mrem_q >= RW'(size_q)) mrem_q <= mrem_q - RW'(size_q);
          else begin
            home_q <= SW'(mrem_q); pos_q <= SW'(mrem_q); steps_q <= '0; probes_q <= '0;
            state_q <= S_STEP;
          end
        end
        S_STEP: begin  // reduce step below size
          if (step_q >= RW'(size_q)) step_q <= step_q - RW'(size_q);
          else state_q <= S_RD;
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (!occ_rd_q) begin
            if (ins_q != '1) ins_q <= ins_q + 32'd1;
            out_q.slot <= 10'(pos_q); out_q.outcome <= 1'b0;
            out_q.probe_collisions <= 11'(probes_q);
            out_q.total_inserts <= (ins_q != '1) ? ins_q + 32'd1 : ins_q;
            out_q.total_collisions <= col_q; out_q.total_replacements <= rep_q;
            state_q <= S_OUT;
          end else if (steps_q == PW'(size_q)) begin
            // walk exhausted; size steps bring pos back to home
            if (rep_q != '1) rep_q <= rep_q + 32'd1;
            out_q.slot <= 10'(home_q); out_q.outcome <= 1'b1;
            out_q.probe_collisions <= 11'(probes_q);
            out_q.total_inserts <= ins_q; out_q.total_collisions <= col_q;
            out_q.total_replacements <= (rep_q != '1) ? rep_q + 32'd1 : rep_q;
            state_q <= S_OUT;
          end else begin
            if (col_q != '1) col_q <= col_q + 32'd1;
            probes_q <= probes_q + PW'(1);
            steps_q <= steps_q + PW'(1);
            pos_q <= nxt;
            state_q <= (steps_q + PW'(1) == PW'(size_q)) ? S_CHK : S_RD;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_ready_i) |=> $stable(out_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHK |-> steps_q <= PW'(size_q))
    else $error("probe walk overran table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> done_clr_q)
    else $error("accepted before clear pass");
endmodule
`default_nettype wire

// ----- design/open_address_hash_insert_top.sv -----
// Top level of the open-address hash insert block.
`default_nettype none
// Inserts BCD keys into an open-addressed table of TABLE_DEPTH slots and
// returns one result per key. After reset a clearing pass empties the
// occupancy memory; the front queue may take up to two keys meanwhile,
// but none enters the back end until the pass is done. An insert first
// finds the home slot with an iterative subtract modulo, then reduces the
// step below the table size, then walks the probe sequence with an
// occupancy memory read for each probe; a full walk replaces the home entry. A
// two-entry queue lets keys be hashed while the back end walks.
module open_address_hash_insert_top import oahi_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_data_o
);
  logic        method_q;
  logic [10:0] size_q;
  logic        jv, jr;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 1'b0;
      size_q <= (TABLE_DEPTH < 1024) ? 11'(TABLE_DEPTH) : 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHashMethod: method_q <= cfg_data_i[0];
        CfgTableSize:  size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  oahi_front u_front (
    .clk_i, .rst_ni, .hash_method_i(method_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  oahi_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .table_size_i(size_q),
    .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
`default_nettype wire
